// ===== rtl/assert_macros.svh =====
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define ASSERT_HOLDS(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/fet_pkg.sv =====
`timescale 1ns / 1ps

package fet_pkg;

  // Default coordinate format: signed Q4.28
  localparam int COORD_WIDTH = 32;
  localparam int FRAC_BITS   = 28;

  // Digit width of the shared multiplier (coordinate x digit per cycle)
  localparam int DIGIT_W = 16;

  // Iteration count / limit
  localparam int COUNT_W = 16;
  localparam logic [COUNT_W-1:0] LIMIT_RESET = 16'd100;

  // Register map
  localparam int CFG_INDEX_W = 2;
  localparam logic [CFG_INDEX_W-1:0] REG_MODE     = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_LIMIT    = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_JULIA_RE = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_JULIA_IM = 2'd3;

endpackage

// ===== rtl/fractal_escape_time_iterator.sv =====
// Escape-time iterator for Mandelbrot and Julia sets.
// Input channel (in_valid/in_ready) carries one point, point_re/point_im, signed
// fixed point with FRAC_BITS fraction bits. Output channel (out_valid/out_ready)
// returns one beat per point: escape_count, the iteration index at which
// z = z*z + c left the radius-2 disc, or iteration_limit if it never did.
// Configuration is a plain write port (cfg_write, cfg_index, cfg_data): mode,
// iteration limit and the Julia constant; write it only while the block is idle.
// One multiplier of COORD_WIDTH x DIGIT_W bits, fed with magnitudes and the
// sign applied after, is shared by the three products of an iteration (zr*zr,
// zi*zi, zr*zi); each product loads in S_SETUP, accumulates its digits in S_MUL
// and ends in S_FIN, with D = ceil(COORD_WIDTH / DIGIT_W) digits (D = 2 by default).
// An iteration runs its three products and S_ADD, S_RANGE and S_CHECK; in Julia
// mode the squares of the start point are formed first. A zero limit returns 0.
// in_ready is high only while no point is being iterated; the result sits in an
// output register, so the next point is taken while it waits. If the receiver
// stalls when a further result is ready, the iterator holds until it is taken.
// Reset (rst, synchronous) empties the output, stops any point in flight and
// returns the registers to Mandelbrot mode, limit 100, Julia constant zero.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module fractal_escape_time_iterator #(
  parameter int COORD_WIDTH = fet_pkg::COORD_WIDTH,
  parameter int FRAC_BITS   = fet_pkg::FRAC_BITS
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_write,
  input  logic [fet_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [COORD_WIDTH-1:0]              cfg_data,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [COORD_WIDTH-1:0]       point_re,
  input  logic signed [COORD_WIDTH-1:0]       point_im,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [fet_pkg::COUNT_W-1:0]         escape_count
);

  localparam int CW     = COORD_WIDTH;
  localparam int PW     = 2 * CW;
  localparam int NW     = PW + 1;
  localparam int DW     = fet_pkg::DIGIT_W;
  localparam int DIGITS = (CW + DW - 1) / DW;
  localparam int MBW    = DIGITS * DW;
  localparam int ACCW   = CW + MBW;
  localparam int PPW    = CW + DW;
  localparam int DCW    = $clog2(DIGITS + 1);
  localparam int LW     = fet_pkg::COUNT_W;

  localparam logic signed [NW-1:0] TWO  = NW'(2) << FRAC_BITS;
  localparam logic signed [NW-1:0] NTWO = -TWO;
  localparam logic signed [NW-1:0] FOUR = NW'(1) << (2 * FRAC_BITS + 2);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_LOAD  = 4'd1;
  localparam logic [3:0] S_SETUP = 4'd2;
  localparam logic [3:0] S_MUL   = 4'd3;
  localparam logic [3:0] S_FIN   = 4'd4;
  localparam logic [3:0] S_ADD   = 4'd5;
  localparam logic [3:0] S_RANGE = 4'd6;
  localparam logic [3:0] S_CHECK = 4'd7;

  localparam logic [1:0] SEL_SR = 2'd0;
  localparam logic [1:0] SEL_SI = 2'd1;
  localparam logic [1:0] SEL_P  = 2'd2;

  // Configuration registers
  logic                  mode;
  logic [LW-1:0]         limit;
  logic signed [CW-1:0]  julia_re;
  logic signed [CW-1:0]  julia_im;

  // Sequencer
  logic [3:0]            state;
  logic [1:0]            sel;
  logic                  first;
  logic [LW-1:0]         i;
  logic [DCW-1:0]        dcnt;

  // Datapath
  logic signed [CW-1:0]  zr, zi, cr, ci;
  logic signed [PW-1:0]  sr, si, p;
  logic signed [NW-1:0]  nr, ni;
  logic [CW-1:0]         ma;
  logic [MBW-1:0]        mb;
  logic                  neg;
  logic [ACCW-1:0]       acc;
  logic [LW-1:0]         res;

  logic                  accept;
  logic                  out_free;
  logic                  finish_req;
  logic [LW-1:0]         fin_count;
  logic signed [CW-1:0]  opa, opb;
  logic [CW-1:0]         abs_a, abs_b;
  logic [DW-1:0]         digit;
  logic [PPW-1:0]        pp;
  logic [ACCW-1:0]       acc_sum;
  logic [PW-1:0]         acc_lo;
  logic signed [PW-1:0]  prod;
  logic signed [PW-1:0]  sr_sh, si_sh, p_sh;
  logic signed [NW-1:0]  nr_calc, ni_calc, mag;
  logic                  range_esc;
  logic                  mag_esc;
  logic [LW-1:0]         i_inc;

  // Config write port
  always_ff @(posedge clk) begin
    if (rst) begin
      mode     <= 1'b0;
      limit    <= fet_pkg::LIMIT_RESET;
      julia_re <= '0;
      julia_im <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        fet_pkg::REG_MODE:     mode     <= cfg_data[0];
        fet_pkg::REG_LIMIT:    limit    <= cfg_data[LW-1:0];
        fet_pkg::REG_JULIA_RE: julia_re <= $signed(cfg_data);
        fet_pkg::REG_JULIA_IM: julia_im <= $signed(cfg_data);
        default: ;
      endcase
    end
  end

  assign in_ready     = (state == S_IDLE);
  assign accept       = in_valid && in_ready;
  assign out_free     = !out_valid || out_ready;
  assign escape_count = res;

  // Multiplier operand select and magnitudes
  assign opa   = (sel == SEL_SI) ? zi : zr;
  assign opb   = (sel == SEL_SR) ? zr : zi;
  assign abs_a = opa[CW-1] ? ((~opa) + CW'(1)) : opa;
  assign abs_b = opb[CW-1] ? ((~opb) + CW'(1)) : opb;

  // One digit of |b| per cycle, most significant first
  assign digit   = mb[MBW-1 -: DW];
  assign pp      = PPW'(ma) * PPW'(digit);
  assign acc_sum = {acc[ACCW-DW-1:0], {DW{1'b0}}} + ACCW'(pp);
  assign acc_lo  = acc[PW-1:0];
  assign prod    = neg ? $signed((~acc_lo) + PW'(1)) : $signed(acc_lo);

  // z update terms, floor scaling by arithmetic shift
  assign sr_sh   = sr >>> FRAC_BITS;
  assign si_sh   = si >>> FRAC_BITS;
  assign p_sh    = p >>> (FRAC_BITS - 1);
  assign nr_calc = NW'(sr_sh) - NW'(si_sh) + NW'(cr);
  assign ni_calc = NW'(p_sh) + NW'(ci);

  // Escape tests
  assign range_esc = (nr > TWO) || (nr < NTWO) || (ni > TWO) || (ni < NTWO);
  assign mag       = NW'(sr) + NW'(si);
  assign mag_esc   = (mag > FOUR);
  assign i_inc     = i + LW'(1);

  // Result decision
  always_comb begin
    finish_req = 1'b0;
    fin_count  = '0;
    case (state)
      S_LOAD: begin
        if (limit == '0) finish_req = 1'b1;
      end
      S_RANGE: begin
        if (range_esc) begin
          finish_req = 1'b1;
          fin_count  = i;
        end
      end
      S_CHECK: begin
        if (!first) begin
          if (mag_esc) begin
            finish_req = 1'b1;
            fin_count  = i;
          end else if (i_inc == limit) begin
            finish_req = 1'b1;
            fin_count  = limit;
          end
        end
      end
      default: ;
    endcase
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      sel       <= SEL_SR;
      first     <= 1'b0;
      i         <= '0;
      dcnt      <= '0;
      out_valid <= 1'b0;
    end else begin
      // a new result wins over the beat leaving in the same cycle
      if (finish_req && out_free) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (accept) begin
            state <= S_LOAD;
            first <= mode;
            i     <= '0;
          end
        end
        S_LOAD: begin
          if (finish_req) begin
            if (out_free) state <= S_IDLE;
          end else begin
            sel   <= mode ? SEL_SR : SEL_P;
            state <= S_SETUP;
          end
        end
        S_SETUP: begin
          dcnt  <= DCW'(DIGITS);
          state <= S_MUL;
        end
        S_MUL: begin
          dcnt <= dcnt - DCW'(1);
          if (dcnt == DCW'(1)) state <= S_FIN;
        end
        S_FIN: begin
          case (sel)
            SEL_SR: begin
              sel   <= SEL_SI;
              state <= S_SETUP;
            end
            SEL_SI:  state <= S_CHECK;
            default: state <= S_ADD;
          endcase
        end
        S_ADD: state <= S_RANGE;
        S_RANGE: begin
          if (finish_req) begin
            if (out_free) state <= S_IDLE;
          end else begin
            sel   <= SEL_SR;
            state <= S_SETUP;
          end
        end
        S_CHECK: begin
          if (finish_req) begin
            if (out_free) state <= S_IDLE;
          end else begin
            if (!first) i <= i_inc;
            first <= 1'b0;
            sel   <= SEL_P;
            state <= S_SETUP;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (accept) begin
      if (mode) begin
        zr <= point_re;
        zi <= point_im;
        cr <= julia_re;
        ci <= julia_im;
      end else begin
        zr <= '0;
        zi <= '0;
        cr <= point_re;
        ci <= point_im;
      end
      sr <= '0;
      si <= '0;
    end
    if (finish_req && out_free) res <= fin_count;
    case (state)
      S_SETUP: begin
        ma  <= abs_a;
        mb  <= MBW'(abs_b);
        neg <= opa[CW-1] ^ opb[CW-1];
        acc <= '0;
      end
      S_MUL: begin
        acc <= acc_sum;
        mb  <= mb << DW;
      end
      S_FIN: begin
        case (sel)
          SEL_SR:  sr <= prod;
          SEL_SI:  si <= prod;
          default: p  <= prod;
        endcase
      end
      S_ADD: begin
        nr <= nr_calc;
        ni <= ni_calc;
      end
      S_RANGE: begin
        if (!range_esc) begin
          zr <= nr[CW-1:0];
          zi <= ni[CW-1:0];
        end
      end
      default: ;
    endcase
  end

  // Checks
  `ASSERT_NEXT(a_load_after_accept, clk, rst, accept, state == S_LOAD, "accepted beat not loaded")
  `ASSERT_HOLDS(a_count_in_limit, clk, rst, finish_req, fin_count <= limit, "count above limit")
  `ASSERT_HOLDS(a_squares_nonneg, clk, rst, state == S_CHECK, !sr[PW-1] && !si[PW-1], "negative square")
  `ASSERT_HOLDS(a_mul_digits, clk, rst, state == S_MUL, dcnt != '0, "multiplier digit count ran out")

endmodule
